/* sv/dbstg_pkg.sv */
// Package for the double-buffered sine table generator.
// Payload structs, sequencer states and fixed-point constants; no dependencies.
package dbstg_pkg;

	localparam int unsigned FREQ_W = 19;
	localparam int unsigned RATE_W = 18;
	localparam int unsigned SMP_W  = 16;
	localparam int unsigned LEN_W  = 11;

	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	typedef struct packed {
		logic              func;
		logic [FREQ_W-1:0] freq_q4;
	} in_beat_t;

	typedef struct packed {
		logic [SMP_W-1:0] sample;
		logic             sample_valid;
		logic [LEN_W-1:0] table_length;
		logic             length_clipped;
		logic             swap_done;
	} out_beat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NDIV,     // rate<<F / freq, one quotient bit a cycle
		ST_NCLAMP,
		ST_PDIV,     // phase i<<32 / N, one bit a cycle
		ST_ANGLE,    // x = r*halfpi
		ST_X2,       // x2 = x*x
		ST_MUL,      // x2*t
		ST_DIVK,     // /k as a reciprocal multiply
		ST_SMUL,     // x*t
		ST_AMUL,     // A*s
		ST_WRITE,
		ST_TICK,
		ST_OUT
	} state_t;

	// Horner divisors 110, 72, 42, 20, 6 as floor(a/k) = ((a >> pre) * mul) >> post,
	// exact for every dividend below 2^32
	function automatic logic [2:0] horner_pre(input logic [2:0] idx);
		case (idx)
			3'd0:    horner_pre = 3'd1;
			3'd1:    horner_pre = 3'd3;
			3'd2:    horner_pre = 3'd1;
			3'd3:    horner_pre = 3'd2;
			default: horner_pre = 3'd1;
		endcase
	endfunction

	function automatic logic [31:0] horner_mul(input logic [2:0] idx);
		case (idx)
			3'd0:    horner_mul = 32'd2498890064;
			3'd1:    horner_mul = 32'd954437177;
			3'd2:    horner_mul = 32'd3272356036;
			3'd3:    horner_mul = 32'd3435973837;
			default: horner_mul = 32'd2863311531;
		endcase
	endfunction

	function automatic logic [5:0] horner_post(input logic [2:0] idx);
		case (idx)
			3'd0:    horner_post = 6'd37;
			3'd1:    horner_post = 6'd33;
			3'd2:    horner_post = 6'd36;
			3'd3:    horner_post = 6'd34;
			default: horner_post = 6'd33;
		endcase
	endfunction

endpackage

/* sv/double_buffered_sine_table_generator_unit.sv */
// Double-buffered sine table generator: request fills idle table, ticks play.
// Ticks pass ST_TICK (table read) and ST_OUT (result load); a new beat is taken only
// in ST_IDLE, after the last one is loaded. A request runs the divider for N
// (skipped at zero frequency), then per sample the divider for the phase and the
// shared 32x32 multiplier for the sine. Output register lets the next beat start
// while a result waits. Reset (arst_n low) clears control state.
module double_buffered_sine_table_generator_unit #(
	parameter int unsigned TABLE_SIZE = 1024,
	parameter int unsigned AMPLITUDE  = 2047,
	parameter int unsigned FREQ_FRAC_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dbstg_pkg::in_beat_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output dbstg_pkg::out_beat_t out_data,
	input  logic cfg_we,
	input  logic [dbstg_pkg::RATE_W-1:0] cfg_wdata
);
	localparam int unsigned AW = $clog2(TABLE_SIZE);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned NUM_W = dbstg_pkg::RATE_W + FREQ_FRAC_BITS;
	// divider width covers N dividend and phase dividend (LW+32)
	localparam int unsigned DW = (NUM_W > LW + 32) ? NUM_W : LW + 32;

	dbstg_pkg::state_t state_q, state_d;

	logic [dbstg_pkg::RATE_W-1:0] rate_q;
	logic [dbstg_pkg::SMP_W-1:0] mem_a [TABLE_SIZE];
	logic [dbstg_pkg::SMP_W-1:0] mem_b [TABLE_SIZE];
	logic [dbstg_pkg::SMP_W-1:0] rd_q;

	logic front_sel_q, pend_q, play_q;
	logic [LW-1:0] front_len_q, back_len_q, n_q;
	logic [AW-1:0] pidx_q;
	logic [LW-1:0] i_q;
	logic clip_q;
	logic func_q;
	logic [dbstg_pkg::FREQ_W-1:0] freq_q;

	// shared divider (restoring, one bit a cycle)
	logic [DW-1:0] dnum_q, dquo_q;
	logic [DW:0] drem_q;
	logic [DW-1:0] dden_q;
	logic [6:0] dcnt_q;
	logic [DW:0] drem_sh;
	logic dge;

	// shared multiplier
	logic [31:0] ma, mb;
	logic [63:0] mprod;
	logic [63:0] mp_q;

	logic [1:0] quad_q;
	logic [31:0] x_q, x2_q, t_q;
	logic [2:0] k_q;
	logic [dbstg_pkg::SMP_W-1:0] smp_q;

	dbstg_pkg::out_beat_t res_q;
	logic ovalid_q;

	assign in_ready  = (state_q == dbstg_pkg::ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = res_q;

	assign drem_sh = {drem_q[DW-1:0], dnum_q[DW-1]};
	assign dge = drem_sh >= {1'b0, dden_q};
	assign mprod = ma * mb;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dbstg_pkg::ST_IDLE:
				if (in_valid && in_ready)
					state_d = (in_data.func == dbstg_pkg::FUNC_TICK) ?
						dbstg_pkg::ST_TICK :
						(in_data.freq_q4 == '0 ? dbstg_pkg::ST_NCLAMP :
						dbstg_pkg::ST_NDIV);
			dbstg_pkg::ST_NDIV:  if (dcnt_q == '0) state_d = dbstg_pkg::ST_NCLAMP;
			dbstg_pkg::ST_NCLAMP: state_d = dbstg_pkg::ST_PDIV;
			dbstg_pkg::ST_PDIV:  if (dcnt_q == '0) state_d = dbstg_pkg::ST_ANGLE;
			dbstg_pkg::ST_ANGLE: state_d = dbstg_pkg::ST_X2;
			dbstg_pkg::ST_X2:    state_d = dbstg_pkg::ST_DIVK;
			dbstg_pkg::ST_MUL:   state_d = dbstg_pkg::ST_DIVK;
			dbstg_pkg::ST_DIVK:
				state_d = (k_q == 3'd4) ? dbstg_pkg::ST_SMUL : dbstg_pkg::ST_MUL;
			dbstg_pkg::ST_SMUL:  state_d = dbstg_pkg::ST_AMUL;
			dbstg_pkg::ST_AMUL:  state_d = dbstg_pkg::ST_WRITE;
			dbstg_pkg::ST_WRITE:
				state_d = (i_q + 1'b1 >= n_q) ? dbstg_pkg::ST_OUT : dbstg_pkg::ST_PDIV;
			dbstg_pkg::ST_TICK:  state_d = dbstg_pkg::ST_OUT;
			// hold while the previous result still waits
			dbstg_pkg::ST_OUT:
				if (!ovalid_q || out_ready) state_d = dbstg_pkg::ST_IDLE;
			default:             state_d = dbstg_pkg::ST_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		ma = x_q;
		mb = x_q;
		unique case (state_q)
			dbstg_pkg::ST_ANGLE: begin
				ma = {2'b0, (quad_q[0] ? (dbstg_pkg::Q30_ONE[29:0] - dquo_q[29:0]) :
					dquo_q[29:0])};
				if (quad_q[0] && dquo_q[29:0] == '0) ma = {1'b0, dbstg_pkg::Q30_ONE};
				mb = dbstg_pkg::HALF_PI_Q30;
			end
			dbstg_pkg::ST_X2:   begin ma = mp_q[61:30]; mb = mp_q[61:30]; end
			dbstg_pkg::ST_MUL:  begin ma = x2_q; mb = t_q; end
			dbstg_pkg::ST_DIVK: begin
				ma = mp_q[61:30] >> dbstg_pkg::horner_pre(k_q);
				mb = dbstg_pkg::horner_mul(k_q);
			end
			dbstg_pkg::ST_SMUL: begin ma = x_q;  mb = t_q; end
			dbstg_pkg::ST_AMUL: begin
				ma = (mp_q[61:30] > {1'b0, dbstg_pkg::Q30_ONE}) ?
					{1'b0, dbstg_pkg::Q30_ONE} : mp_q[61:30];
				mb = 32'(AMPLITUDE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbstg_pkg::ST_IDLE;
			rate_q <= dbstg_pkg::RATE_W'(48000);
			front_sel_q <= 1'b0;
			pend_q <= 1'b0;
			play_q <= 1'b0;
			front_len_q <= '0;
			back_len_q <= '0;
			pidx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) rate_q <= cfg_wdata;
			// load a new result, else drop the one taken
			if (state_q == dbstg_pkg::ST_OUT && state_d == dbstg_pkg::ST_IDLE)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
			// request commits table
			if (state_q == dbstg_pkg::ST_WRITE && state_d == dbstg_pkg::ST_OUT) begin
				back_len_q <= n_q;
				if (!play_q) begin
					front_sel_q <= ~front_sel_q;
					front_len_q <= n_q;
					pidx_q <= '0;
					play_q <= 1'b1;
				end else begin
					pend_q <= 1'b1;
				end
			end
			// advance playback
			if (state_q == dbstg_pkg::ST_TICK && play_q) begin
				if (LW'(pidx_q) + 1'b1 >= front_len_q) begin
					pidx_q <= '0;
					if (pend_q) begin
						front_sel_q <= ~front_sel_q;
						front_len_q <= back_len_q;
						pend_q <= 1'b0;
					end
				end else begin
					pidx_q <= pidx_q + 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			dbstg_pkg::ST_IDLE: if (in_valid && in_ready) begin
				func_q <= in_data.func;
				freq_q <= in_data.freq_q4;
				dnum_q <= DW'(rate_q) << (DW - dbstg_pkg::RATE_W);
				dden_q <= DW'(in_data.freq_q4);
				drem_q <= '0;
				dquo_q <= '0;
				dcnt_q <= 7'(NUM_W - 1);
			end
			dbstg_pkg::ST_NDIV, dbstg_pkg::ST_PDIV: begin
				drem_q <= dge ? drem_sh - {1'b0, dden_q} : drem_sh;
				dquo_q <= {dquo_q[DW-2:0], dge};
				dnum_q <= dnum_q << 1;
				if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
				// quadrant from the last phase quotient bits
				if (state_q == dbstg_pkg::ST_PDIV && dcnt_q == '0)
					quad_q <= dquo_q[30:29];
			end
			dbstg_pkg::ST_NCLAMP: begin
				if (freq_q == '0) begin
					n_q <= LW'(TABLE_SIZE); clip_q <= 1'b1;
				end else if (dquo_q == '0) begin
					n_q <= LW'(1); clip_q <= 1'b1;
				end else if (dquo_q > DW'(TABLE_SIZE)) begin
					n_q <= LW'(TABLE_SIZE); clip_q <= 1'b1;
				end else begin
					n_q <= LW'(dquo_q); clip_q <= 1'b0;
				end
				i_q <= '0;
				// phase dividend for sample zero is zero
				dnum_q <= '0;
				dquo_q <= '0;
				dden_q <= (freq_q == '0 || dquo_q > DW'(TABLE_SIZE)) ? DW'(TABLE_SIZE) :
					(dquo_q == '0 ? DW'(1) : dquo_q);
				drem_q <= '0;
				dcnt_q <= 7'(LW + 31);
			end
			dbstg_pkg::ST_ANGLE: begin
				mp_q <= mprod;
			end
			dbstg_pkg::ST_X2: begin
				x_q <= mp_q[61:30];
				x2_q <= mprod[61:30];
				mp_q <= mprod;
				k_q <= 3'd0;
			end
			dbstg_pkg::ST_MUL: mp_q <= mprod;
			// t = 1 - dividend/k, then advance to the next Horner stage
			dbstg_pkg::ST_DIVK: begin
				t_q <= 32'(dbstg_pkg::Q30_ONE) -
					32'(mprod >> dbstg_pkg::horner_post(k_q));
				k_q <= k_q + 1'b1;
			end
			dbstg_pkg::ST_SMUL: mp_q <= mprod;
			dbstg_pkg::ST_AMUL: begin
				if (quad_q[1] == 1'b0)
					smp_q <= dbstg_pkg::SMP_W'(AMPLITUDE + 32'(mprod >> 30));
				else
					smp_q <= dbstg_pkg::SMP_W'(AMPLITUDE - 32'((mprod + 64'h3FFF_FFFF) >> 30));
			end
			dbstg_pkg::ST_WRITE: begin
				i_q <= i_q + 1'b1;
				dnum_q <= DW'({i_q + 1'b1, 32'b0}) << (DW - LW - 32);
				drem_q <= '0;
				dquo_q <= '0;
				dcnt_q <= 7'(LW + 31);
			end
			default: ;
		endcase
	end

	// table write and playback read
	always_ff @(posedge clk) begin
		if (state_q == dbstg_pkg::ST_WRITE) begin
			if (front_sel_q) mem_a[i_q[AW-1:0]] <= smp_q;
			else mem_b[i_q[AW-1:0]] <= smp_q;
		end
		if (state_q == dbstg_pkg::ST_TICK)
			rd_q <= front_sel_q ? mem_b[pidx_q] : mem_a[pidx_q];
	end

	// result register
	logic tick_play_q, tick_swap_q;
	always_ff @(posedge clk) begin
		if (state_q == dbstg_pkg::ST_TICK) begin
			tick_play_q <= play_q;
			tick_swap_q <= play_q && pend_q && (LW'(pidx_q) + 1'b1 >= front_len_q);
		end
		if (state_q == dbstg_pkg::ST_OUT && state_d == dbstg_pkg::ST_IDLE) begin
			if (func_q == dbstg_pkg::FUNC_TICK) begin
				res_q.sample         <= tick_play_q ? rd_q : '0;
				res_q.sample_valid   <= tick_play_q;
				res_q.table_length   <= dbstg_pkg::LEN_W'(front_len_q);
				res_q.length_clipped <= 1'b0;
				res_q.swap_done      <= tick_swap_q;
			end else begin
				res_q.sample         <= '0;
				res_q.sample_valid   <= 1'b0;
				res_q.table_length   <= dbstg_pkg::LEN_W'(n_q);
				res_q.length_clipped <= clip_q;
				res_q.swap_done      <= 1'b0;
			end
		end
	end

endmodule
